>>> rtl/core/trilinear_grid_sampler_assert.svh
// Assertion macros for the trilinear grid sampler checker.
// Used by tgs_checker; expects clk and rst in scope.
`ifndef TRILINEAR_GRID_SAMPLER_ASSERT_SVH
`define TRILINEAR_GRID_SAMPLER_ASSERT_SVH

// same-cycle implication
`define TGS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgs assertion failed");

// next-cycle implication
`define TGS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgs assertion failed");

`endif

>>> rtl/core/tgs_pkg.sv
// Shared types, constants and helpers for the trilinear grid sampler.
// No dependencies.
`timescale 1ns / 1ps
package tgs_pkg;
  localparam int NX = 32;
  localparam int NY = 32;
  localparam int NZ = 32;
  localparam int CW = 8;
  localparam int WW = 17;
  localparam int IDX_W = 15;
  localparam int STORE_DEPTH = 2 ** IDX_W;
  localparam int DATA_W = 32;
  localparam int SP_W = 31;
  localparam int QBITS = CW + 16;
  localparam int DIV_BITS = 3;
  localparam int DIV_STEPS = QBITS / DIV_BITS;
  localparam int QDEPTH = 2;
  localparam int OFIFO_DEPTH = 4;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W = 88;

  localparam logic [WW-1:0] Q_ONE = WW'(65536);
  localparam logic [SP_W-1:0] SP_RESET = SP_W'(65536);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 3'd5;

  typedef struct packed {
    logic [CW-1:0] lo;
    logic [WW-1:0] w;
  } axis_t;

  typedef struct packed {
    logic op;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] value;
    axis_t ax;
    axis_t ay;
    axis_t az;
  } item_t;

  function automatic int grid_dim(input int a);
    int n;
    case (a)
      0: n = NX;
      1: n = NY;
      default: n = NZ;
    endcase
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] corner_index(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y,
                                                   input logic [CW-1:0] z);
    logic [31:0] t;
    t = 32'(x) + 32'(NX) * (32'(y) + 32'(NY) * 32'(z));
    return t[IDX_W-1:0];
  endfunction
endpackage

>>> rtl/core/tgs_front.sv
// Front end: takes input transactions, maps query points to grid cells.
// Radix-8 restoring divider per axis; depends on tgs_pkg.
`timescale 1ns / 1ps
module tgs_front
  import tgs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_op,
  input  logic [IDX_W-1:0] in_idx,
  input  logic [DATA_W-1:0] in_value,
  input  logic [2:0][DATA_W-1:0] in_pt,
  input  logic [2:0][DATA_W-1:0] origin,
  input  logic [2:0][SP_W-1:0] spacing,
  output logic out_valid,
  input  logic out_ready,
  output item_t out_item
);
  localparam int CNT_W = $clog2(DIV_STEPS);

  logic busy, done;
  logic [CNT_W-1:0] cnt;
  logic op;
  logic [IDX_W-1:0] idx;
  logic [DATA_W-1:0] value;
  logic [2:0] neg, clamp;
  logic [2:0][SP_W-1:0] s;
  logic [2:0][SP_W-1:0] rem, rem_next;
  logic [2:0][QBITS-1:0] low, low_next;
  logic [2:0][QBITS-1:0] q, q_next;
  logic [2:0][DATA_W:0] d;
  logic [2:0][SP_W-1:0] s_in;
  logic [2:0] clamp_in;
  logic accept, pop;
  axis_t [2:0] ax;

  assign pop = out_valid && out_ready;
  assign in_ready = !busy || (done && out_ready);
  assign accept = in_valid && in_ready;
  assign out_valid = busy && done;

  always_comb begin
    logic [38:0] lim;
    for (int a = 0; a < 3; a++) begin
      d[a] = {in_pt[a][DATA_W-1], in_pt[a]} - {origin[a][DATA_W-1], origin[a]};
      s_in[a] = (spacing[a] == '0) ? SP_W'(1) : spacing[a];
      lim = 39'(grid_dim(a) - 1) * 39'(s_in[a]);
      clamp_in[a] = !d[a][DATA_W] && ({7'b0, d[a][DATA_W-1:0]} >= lim);
    end
  end

  always_comb begin
    logic [SP_W:0] r2;
    rem_next = rem;
    low_next = low;
    q_next = q;
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < DIV_BITS; j++) begin
        r2 = {rem_next[a], low_next[a][QBITS-1]};
        low_next[a] = {low_next[a][QBITS-2:0], 1'b0};
        if (r2 >= {1'b0, s[a]}) begin
          r2 = r2 - {1'b0, s[a]};
          q_next[a] = {q_next[a][QBITS-2:0], 1'b1};
        end else begin
          q_next[a] = {q_next[a][QBITS-2:0], 1'b0};
        end
        rem_next[a] = r2[SP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      done <= (in_op == OP_WRITE);
      cnt <= '0;
    end else if (pop) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (busy && !done) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= in_op;
      idx <= in_idx;
      value <= in_value;
      for (int a = 0; a < 3; a++) begin
        neg[a] <= d[a][DATA_W];
        clamp[a] <= clamp_in[a];
        s[a] <= s_in[a];
        rem[a] <= SP_W'(d[a][DATA_W-1:8]);
        low[a] <= {d[a][7:0], 16'h0};
        q[a] <= '0;
      end
    end else if (busy && !done) begin
      rem <= rem_next;
      low <= low_next;
      q <= q_next;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (neg[a]) begin
        ax[a].lo = '0;
        ax[a].w = '0;
      end else if (clamp[a]) begin
        ax[a].lo = CW'(grid_dim(a) - 2);
        ax[a].w = Q_ONE;
      end else begin
        ax[a].lo = q[a][QBITS-1:16];
        ax[a].w = {1'b0, q[a][15:0]};
      end
    end
  end

  assign out_item = '{op: op, idx: idx, value: value, ax: ax[0], ay: ax[1], az: ax[2]};
endmodule

>>> rtl/core/tgs_queue.sv
// Short FIFO of decoded transactions between front end and back end.
// Depends on tgs_pkg.
`timescale 1ns / 1ps
module tgs_queue
  import tgs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output item_t out_item
);
  localparam int PW = $clog2(QDEPTH);

  item_t mem [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0] count;
  logic push, pop;

  assign in_ready = (count != (PW+1)'(QDEPTH));
  assign out_valid = (count != '0);
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
  end
endmodule

>>> rtl/core/tgs_back.sv
// Back end: grid memory, eight corner reads per query, weight pipeline,
// accumulator and result FIFO. Depends on tgs_pkg.
`timescale 1ns / 1ps
module tgs_back
  import tgs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output logic [DATA_W-1:0] out_data
);
  localparam int FW = $clog2(OFIFO_DEPTH);

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [2:0] corner;
  logic [FW:0] pend;
  logic is_write, issue, start, opop;
  logic [CW-1:0] cx, cy, cz;
  logic [WW-1:0] wx, wy, wz;
  logic [IDX_W-1:0] raddr;

  logic v1, v2, v3, v4, fin;
  logic f1, f2, f3, f4, l1, l2, l3, l4;
  logic [WW-1:0] wx1, wy1, wy2, wz1, wz2, wz3;
  logic signed [48:0] p1;
  logic signed [66:0] p2;
  logic signed [84:0] p3;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rnd;

  logic [DATA_W-1:0] ofifo [OFIFO_DEPTH];
  logic [FW-1:0] wp, rp;
  logic [FW:0] ocnt;

  assign is_write = in_valid && (in_item.op == OP_WRITE);
  assign issue = in_valid && (in_item.op == OP_QUERY)
                 && ((corner != 3'd0) || (pend < (FW+1)'(OFIFO_DEPTH)));
  assign start = issue && (corner == 3'd0);
  assign in_ready = is_write || (issue && (corner == 3'd7));
  assign opop = out_valid && out_ready;

  always_comb begin
    cx = in_item.ax.lo + CW'(corner[0]);
    cy = in_item.ay.lo + CW'(corner[1]);
    cz = in_item.az.lo + CW'(corner[2]);
    wx = corner[0] ? in_item.ax.w : Q_ONE - in_item.ax.w;
    wy = corner[1] ? in_item.ay.w : Q_ONE - in_item.ay.w;
    wz = corner[2] ? in_item.az.w : Q_ONE - in_item.az.w;
    raddr = corner_index(cx, cy, cz);
  end

  always_ff @(posedge clk) begin
    if (is_write) begin
      mem[in_item.idx] <= in_item.value;
    end else begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= '0;
      pend <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      fin <= 1'b0;
    end else begin
      if (issue) corner <= corner + 1'b1;
      pend <= pend + (FW+1)'(start) - (FW+1)'(opop);
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      fin <= v4 && l4;
    end
  end

  always_ff @(posedge clk) begin
    f1 <= (corner == 3'd0);
    l1 <= (corner == 3'd7);
    wx1 <= wx;
    wy1 <= wy;
    wz1 <= wz;
    p1 <= $signed(rdata) * $signed({1'b0, wx1});
    f2 <= f1;
    l2 <= l1;
    wy2 <= wy1;
    wz2 <= wz1;
    p2 <= p1 * $signed({1'b0, wy2});
    f3 <= f2;
    l3 <= l2;
    wz3 <= wz2;
    p3 <= p2 * $signed({1'b0, wz3});
    f4 <= f3;
    l4 <= l3;
    if (v4) begin
      acc <= (f4 ? '0 : acc) + {{(ACC_W-85){p3[84]}}, p3};
    end
  end

  assign rnd = acc + (ACC_W'(1) << 47);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      ocnt <= '0;
    end else begin
      if (fin) wp <= wp + 1'b1;
      if (opop) rp <= rp + 1'b1;
      ocnt <= ocnt + (FW+1)'(fin) - (FW+1)'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (fin) ofifo[wp] <= rnd[48+DATA_W-1:48];
  end

  assign out_valid = (ocnt != '0);
  assign out_data = ofifo[rp];
endmodule

>>> rtl/core/trilinear_grid_sampler.sv
// Trilinear grid sampler. Write transaction: skips the divider, stored at back end.
// Query: divided in the front-end divider, which takes no new transaction until the
// current one leaves it; 8 corner reads from the single-port grid RAM.
// rst (synchronous) clears handshake state and sets origins to 0, spacings to
// 1.0; grid RAM content is undefined until written.
`timescale 1ns / 1ps
module trilinear_grid_sampler
  import tgs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // sample_index, sample_value, point_x, point_y, point_z
  input  logic [0:0] s_axis_tuser,    // op
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,   // interp_value
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);
  logic [2:0][DATA_W-1:0] origin;
  logic [2:0][SP_W-1:0] spacing;
  logic [2:0][DATA_W-1:0] pt;
  logic f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      spacing <= {3{SP_RESET}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: origin[0] <= cfg_data;
        REG_ORIGIN_Y: origin[1] <= cfg_data;
        REG_ORIGIN_Z: origin[2] <= cfg_data;
        REG_SPACING_X: spacing[0] <= cfg_data[SP_W-1:0];
        REG_SPACING_Y: spacing[1] <= cfg_data[SP_W-1:0];
        REG_SPACING_Z: spacing[2] <= cfg_data[SP_W-1:0];
        default: ;
      endcase
    end
  end

  assign pt[0] = s_axis_tdata[78:47];
  assign pt[1] = s_axis_tdata[110:79];
  assign pt[2] = s_axis_tdata[142:111];

  tgs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tuser[0]), .in_idx(s_axis_tdata[14:0]),
    .in_value(s_axis_tdata[46:15]), .in_pt(pt),
    .origin(origin), .spacing(spacing),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  tgs_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
    .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
  );

  tgs_back u_back (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );
endmodule

>>> rtl/core/tgs_checker.sv
// Port-level checker for trilinear_grid_sampler, bound to the top level.
// Depends on trilinear_grid_sampler_assert.svh.
`timescale 1ns / 1ps
`include "trilinear_grid_sampler_assert.svh"
module tgs_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [0:0] s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  logic [7:0] pend;
  logic q_acc, o_acc;

  assign q_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];
  assign o_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 8'(q_acc) - 8'(o_acc);
    end
  end

  `TGS_ASSERT_IMP(a_result_needs_query, m_axis_tvalid, pend != 8'd0)
  `TGS_ASSERT_IMP(a_quiet_after_reset, $past(rst), !m_axis_tvalid)
  `TGS_ASSERT_NXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind trilinear_grid_sampler tgs_checker u_chk (.*);

>>> tb/sv/trilinear_grid_sampler_tb.sv
// Testbench for trilinear_grid_sampler: directed table then random writes and
// queries, each result checked against a table value or an in-bench Q16.16 trilinear predictor.
// Depends on tgs_pkg and the trilinear_grid_sampler RTL.
`timescale 1ns / 1ps
module trilinear_grid_sampler_tb;
  import tgs_pkg::*;

  localparam longint UNIT = 65536;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic op;
    logic [IDX_W-1:0] idx;
    logic [31:0] val;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } grid_op_t;

  typedef struct {
    grid_op_t t;
    bit chk;
    logic [31:0] res;
  } dir_row_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata;  // sample_index, sample_value, point_x, point_y, point_z
  logic [0:0] s_axis_tuser;    // op
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;   // interp_value
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  logic [31:0] grid_mem [STORE_DEPTH];
  bit grid_written [STORE_DEPTH];
  logic [31:0] org_x, org_y, org_z;
  logic [30:0] spc_x, spc_y, spc_z;
  logic [31:0] interp_q[$];
  int errors;
  int tx_idle_pct;
  int rx_idle_pct;
  int sent;
  bit hold_req;

  trilinear_grid_sampler u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // per-axis lower corner and upper weight
  function automatic void map_axis(input logic [31:0] pt, input logic [31:0] org,
                                   input logic [30:0] sp, input int n,
                                   output int lo, output longint w);
    longint d;
    longint unsigned s;
    longint unsigned q;
    d = longint'($signed(pt)) - longint'($signed(org));
    s = (sp == 0) ? 1 : longint'(sp);
    if (d < 0) begin
      lo = 0;
      w = 0;
    end else begin
      q = (longint'(d) << 16) / s;
      if ((q >> 16) >= n - 1) begin
        lo = n - 2;
        w = UNIT;
      end else begin
        lo = int'(q >> 16);
        w = longint'(q & 16'hFFFF);
      end
    end
  endfunction

  function automatic int corner_addr(input int x, input int y, input int z);
    int t;
    t = x + NX * (y + NY * z);
    return t & (STORE_DEPTH - 1);
  endfunction

  function automatic logic signed [127:0] grid_at(input int x, input int y, input int z);
    logic signed [127:0] v;
    v = $signed(grid_mem[corner_addr(x, y, z)]);
    return v;
  endfunction

  function automatic logic [31:0] interp_point(input grid_op_t t);
    int x0, y0, z0;
    longint fx, fy, fz;
    logic signed [127:0] wx, wy, wz, ay0, ay1, bz0, bz1, tot;
    map_axis(t.px, org_x, spc_x, NX, x0, fx);
    map_axis(t.py, org_y, spc_y, NY, y0, fy);
    map_axis(t.pz, org_z, spc_z, NZ, z0, fz);
    wx = fx;
    wy = fy;
    wz = fz;
    ay0 = grid_at(x0, y0, z0) * (UNIT - wx) + grid_at(x0 + 1, y0, z0) * wx;
    ay1 = grid_at(x0, y0 + 1, z0) * (UNIT - wx) + grid_at(x0 + 1, y0 + 1, z0) * wx;
    bz0 = ay0 * (UNIT - wy) + ay1 * wy;
    ay0 = grid_at(x0, y0, z0 + 1) * (UNIT - wx) + grid_at(x0 + 1, y0, z0 + 1) * wx;
    ay1 = grid_at(x0, y0 + 1, z0 + 1) * (UNIT - wx)
        + grid_at(x0 + 1, y0 + 1, z0 + 1) * wx;
    bz1 = ay0 * (UNIT - wy) + ay1 * wy;
    tot = bz0 * (UNIT - wz) + bz1 * wz;
    tot = (tot + (128'sd1 <<< 47)) >>> 48;
    return tot[31:0];
  endfunction

  task automatic send_op(input grid_op_t t, input bit use_res, input logic [31:0] res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = t.op;
    s_axis_tdata = {1'b0, t.pz, t.py, t.px, t.val, t.idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (t.op == OP_WRITE) begin
      grid_mem[t.idx] = t.val;
      grid_written[t.idx] = 1'b1;
    end else begin
      interp_q.push_back(use_res ? res : interp_point(t));
    end
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X: org_x = val;
      REG_ORIGIN_Y: org_y = val;
      REG_ORIGIN_Z: org_z = val;
      REG_SPACING_X: spc_x = val[30:0];
      REG_SPACING_Y: spc_y = val[30:0];
      REG_SPACING_Z: spc_z = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (interp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord(input logic [31:0] org, input logic [30:0] sp);
    longint p;
    longint s;
    if ($urandom_range(0, 9) == 0) return $urandom;
    s = (sp == 0) ? 1 : longint'(sp);
    p = longint'($signed(org))
      + ((longint'($urandom_range(0, 33 * 65536)) * s) >>> 16) - s;
    if (p < -64'sd2147483648 || p > 64'sd2147483647) return $urandom;
    return p[31:0];
  endfunction

  // random query, preceded by writes to any corner it would read unwritten
  task automatic random_query();
    grid_op_t t, w;
    int x0, y0, z0, a;
    longint f;
    t.op = OP_QUERY;
    t.idx = IDX_W'($urandom);
    t.val = $urandom;
    t.px = pick_coord(org_x, spc_x);
    t.py = pick_coord(org_y, spc_y);
    t.pz = pick_coord(org_z, spc_z);
    map_axis(t.px, org_x, spc_x, NX, x0, f);
    map_axis(t.py, org_y, spc_y, NY, y0, f);
    map_axis(t.pz, org_z, spc_z, NZ, z0, f);
    for (int k = 0; k < 8; k++) begin
      a = corner_addr(x0 + k[0], y0 + k[1], z0 + k[2]);
      if (!grid_written[a]) begin
        w.op = OP_WRITE;
        w.idx = IDX_W'(a);
        w.val = $urandom;
        w.px = $urandom;
        w.py = $urandom;
        w.pz = $urandom;
        send_op(w, 1'b0, '0);
      end
    end
    send_op(t, 1'b0, '0);
  endtask

  task automatic random_write();
    grid_op_t w;
    w.op = OP_WRITE;
    w.idx = IDX_W'($urandom);
    w.val = $urandom;
    w.px = $urandom;
    w.py = $urandom;
    w.pz = $urandom;
    send_op(w, 1'b0, '0);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (interp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== interp_q[0]) begin
          $display("%0t: interp_value expected %h actual %h", $time, interp_q[0],
                   m_axis_tdata);
          errors++;
        end
        void'(interp_q.pop_front());
      end
    end
  end

  dir_row_t dir_rows [23];
  logic [31:0] reg_sets [5][6];

  initial begin
    errors = 0;
    sent = 0;
    hold_req = 1'b0;
    tx_idle_pct = 34;
    rx_idle_pct = 88;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    org_x = 0;
    org_y = 0;
    org_z = 0;
    spc_x = SP_RESET;
    spc_y = SP_RESET;
    spc_z = SP_RESET;
    foreach (grid_written[i]) grid_written[i] = 1'b0;

    dir_rows = '{
      '{'{OP_WRITE, 15'd0, 32'h7FFFFFFF, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd1, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
        1'b0, 32'h0},
      '{'{OP_WRITE, 15'd32, 32'h00010000, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd33, 32'hFFFF0000, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd1024, 32'h12345678, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd1025, 32'h00000000, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd1056, 32'hDEADBEEF, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd1057, 32'h00000001, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd31710, 32'h00ABCDEF, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd31711, 32'hF0F0F0F0, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd31742, 32'h0F0F0F0F, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd31743, 32'h55555555, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd32734, 32'hAAAAAAAA, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd32735, 32'h00000100, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd32766, 32'hFFFFFFFF, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_WRITE, 15'd32767, 32'h80000000, 0, 0, 0}, 1'b0, 32'h0},
      '{'{OP_QUERY, 15'd0, 32'h0, 0, 0, 0}, 1'b1, 32'h7FFFFFFF},
      '{'{OP_QUERY, 15'h7FFF, 32'hFFFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000},
        1'b1, 32'h7FFFFFFF},
      '{'{OP_QUERY, 15'd0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
        1'b1, 32'h80000000},
      '{'{OP_QUERY, 15'd0, 32'h0, 32'h001F0000, 32'h001F0000, 32'h001F0000},
        1'b1, 32'h80000000},
      '{'{OP_QUERY, 15'd0, 32'h0, 32'h00008000, 0, 0}, 1'b0, 32'h0},
      '{'{OP_QUERY, 15'd0, 32'h0, 32'h00008000, 32'h00008000, 32'h00008000},
        1'b0, 32'h0},
      '{'{OP_QUERY, 15'd0, 32'h0, 32'h0000FFFF, 32'h00000001, 32'h00004000},
        1'b0, 32'h0}
    };

    // origins x,y,z then spacings x,y,z
    reg_sets = '{
      '{32'hFFF80000, 32'h00030000, 32'hFFFFFFFF, 32'h00008000, 32'h00020000, 32'h00000001},
      '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF},
      '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000, 32'h80000000, 32'h00000000},
      '{32'h12345678, 32'hEDCBA987, 32'h00000000, 32'h01000000, 32'h00001234, 32'h00ABCDEF},
      '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00010000, 32'h00010000, 32'h00010000}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_op(dir_rows[i].t, dir_rows[i].chk, dir_rows[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph > 0) begin
        for (int r = 0; r < 6; r++) write_reg(r[CFG_IDX_W-1:0], reg_sets[ph-1][r]);
        if (ph == 1) begin
          write_reg(3'd6, 32'hFFFFFFFF);
          write_reg(3'd7, 32'hFFFFFFFF);
        end
      end
      if (ph == 2) begin
        tx_idle_pct = 88;
        rx_idle_pct = 34;
      end
      if (ph == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
      end
      // transaction budget per phase, corner-fill writes included
      while (sent < 23 + (ph + 1) * 171) begin
        if ($urandom_range(0, 9) < 8) random_query();
        else random_write();
      end
    end

    s_axis_tvalid = 1'b0;
    while (interp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
